// File: design/las_pkg.sv
package las_pkg;

  localparam int SCORE_W   = 14;
  localparam int CAND_W    = 16;
  localparam int ROW_W     = 6;
  localparam int BASE_W    = 3;
  localparam int TRACE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;
  localparam int GAP_W     = 7;

  localparam int MAX_QUERY_DEF = 32;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Base codes.
  localparam logic [BASE_W-1:0] BASE_A     = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C     = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G     = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T     = 3'd3;
  localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

  // Operations carried by the opcode field.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

  localparam logic signed [CFG_W-1:0] MATCH_RESET    = 8'sd1;
  localparam logic signed [CFG_W-1:0] MISMATCH_RESET = -8'sd1;
  localparam logic [GAP_W-1:0]        GAP_RESET      = 7'd1;

  // Trace bits.
  localparam int TR_DIAG = 0;
  localparam int TR_UP   = 1;
  localparam int TR_LEFT = 2;

  typedef enum logic [1:0] {
    PAIR_NONE,
    PAIR_MATCH,
    PAIR_MISMATCH
  } pair_kind_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic wr_en;
  } col_ctl_t;

  function automatic logic [BASE_W-1:0] norm_base(input logic [BASE_W-1:0] b);
    norm_base = (b > BASE_OTHER) ? BASE_OTHER : b;
  endfunction

  function automatic pair_kind_t pair_kind(input logic [BASE_W-1:0] q,
                                           input logic [BASE_W-1:0] t);
    pair_kind_t k;
    k = PAIR_MISMATCH;
    if (q >= BASE_OTHER || t >= BASE_OTHER) begin
      k = PAIR_NONE;
    end else if ((q == BASE_A && t == BASE_T) || (q == BASE_T && t == BASE_A) ||
                 (q == BASE_C && t == BASE_G) || (q == BASE_G && t == BASE_C) ||
                 (q == BASE_G && t == BASE_T) || (q == BASE_T && t == BASE_G)) begin
      k = PAIR_MATCH;
    end
    pair_kind = k;
  endfunction

endpackage

// File: design/las_cell.sv
module las_cell (
  input  logic [las_pkg::BASE_W-1:0]         qbase,
  input  logic [las_pkg::BASE_W-1:0]         tbase,
  input  logic signed [las_pkg::CFG_W-1:0]   match_score,
  input  logic signed [las_pkg::CFG_W-1:0]   mismatch_score,
  input  logic [las_pkg::GAP_W-1:0]          gap_cost,
  input  logic [las_pkg::SCORE_W-1:0]        diag,
  input  logic [las_pkg::SCORE_W-1:0]        up,
  input  logic [las_pkg::SCORE_W-1:0]        left,
  output logic [las_pkg::SCORE_W-1:0]        best,
  output logic [las_pkg::TRACE_W-1:0]        trace
);
  import las_pkg::*;

  logic signed [CFG_W-1:0]  pair;
  logic signed [CAND_W-1:0] c_diag;
  logic signed [CAND_W-1:0] c_up;
  logic signed [CAND_W-1:0] c_left;
  logic signed [CAND_W-1:0] top;

  localparam logic signed [CAND_W-1:0] SAT_LIM = $signed({2'b00, SCORE_MAX});

  function automatic logic signed [CAND_W-1:0] sat(input logic signed [CAND_W-1:0] v);
    sat = (v > SAT_LIM) ? SAT_LIM : v;
  endfunction

  always_comb begin
    unique case (pair_kind(qbase, tbase))
      PAIR_MATCH:    pair = match_score;
      PAIR_MISMATCH: pair = mismatch_score;
      default:       pair = '0;
    endcase
  end

  assign c_diag = sat($signed({2'b00, diag}) + $signed({{(CAND_W-CFG_W){pair[CFG_W-1]}}, pair}));
  assign c_up   = sat($signed({2'b00, up})   - $signed({{(CAND_W-GAP_W){1'b0}}, gap_cost}));
  assign c_left = sat($signed({2'b00, left}) - $signed({{(CAND_W-GAP_W){1'b0}}, gap_cost}));

  always_comb begin
    top = c_diag;
    if (c_up > top) begin
      top = c_up;
    end
    if (c_left > top) begin
      top = c_left;
    end
    best  = '0;
    trace = '0;
    // A maximum of zero or below ends the local alignment here.
    if (top > 0) begin
      best           = top[SCORE_W-1:0];
      trace[TR_DIAG] = (c_diag == top);
      trace[TR_UP]   = (c_up == top);
      trace[TR_LEFT] = (c_left == top);
    end
  end

endmodule

// File: design/las_colmem.sv
module las_colmem #(
  parameter int DEPTH = las_pkg::MAX_QUERY_DEF,
  parameter int AW    = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  las_pkg::col_ctl_t            ctl,
  input  logic [AW-1:0]                rd_addr,
  input  logic [AW-1:0]                wr_addr,
  input  logic [las_pkg::SCORE_W-1:0]  wr_data,
  output logic [las_pkg::SCORE_W-1:0]  rd_data
);
  import las_pkg::*;

  logic [SCORE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  logic [SCORE_W-1:0] rd_raw;
  logic               rd_hit;

  // Valid bits stand in for clearing the column: an entry not written
  // since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_hit <= valid[rd_addr] & ~ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

// File: design/local_alignment_score_column.sv
// Local alignment score column.
// Input channel (in_valid / in_stall): each item carries opcode, base and
// first. A load item appends a query base to the query store (first restarts
// the query) and gives no result. A target item computes one column of the
// score matrix, one result per query row, top to bottom.
// Output channel (out_valid / out_stall): row, score, trace and last, with
// last set on the final row of the column.
// A target item reads the first row, passes each row through the single cell
// unit, and then stores the bottom cell. After acceptance the first row is
// read, and its result is then registered to the output. The next item is
// taken once the column is finished. in_stall is high while a column is being
// worked on. A stalled output holds its result and freezes the column walk
// until it is taken. Configuration is written through cfg_write / cfg_index /
// cfg_data; the user must write it only while the block is idle, since the
// block itself does not enforce this.
// Reset clears the query length, the previous column and the registers to
// match 1, mismatch -1 and gap 1.
module local_alignment_score_column #(
  parameter int MAX_QUERY = las_pkg::MAX_QUERY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [las_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [las_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [las_pkg::BASE_W-1:0]        base,
  input  logic                              first,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [las_pkg::ROW_W-1:0]         row,
  output logic [las_pkg::SCORE_W-1:0]       score,
  output logic [las_pkg::TRACE_W-1:0]       trace,
  output logic                              last
);
  import las_pkg::*;

  localparam int AW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int LW = $clog2(MAX_QUERY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]               state;
  logic signed [CFG_W-1:0]  match_score;
  logic signed [CFG_W-1:0]  mismatch_score;
  logic [GAP_W-1:0]         gap_cost;

  logic [LW-1:0]            qlen;
  logic [AW-1:0]            idx;
  logic [SCORE_W-1:0]       diag_val;
  logic [SCORE_W-1:0]       up_val;
  logic [BASE_W-1:0]        tbase;

  logic [BASE_W-1:0]        qmem [MAX_QUERY];
  logic [BASE_W-1:0]        q_rd;

  logic                     accept_in;
  logic                     do_load;
  logic                     do_target;
  logic                     start;
  logic                     advance;
  logic                     last_row;
  logic [LW-1:0]            row_num;
  logic                     q_wr_en;
  logic [AW-1:0]            q_wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            col_wr_addr;
  col_ctl_t                 col_ctl;
  logic [SCORE_W-1:0]       left_val;
  logic [SCORE_W-1:0]       cell_best;
  logic [TRACE_W-1:0]       cell_trace;

  assign in_stall  = (state != ST_IDLE);
  assign accept_in = in_valid & ~in_stall;
  assign do_load   = accept_in & (opcode == OP_LOAD);
  assign do_target = accept_in & (opcode == OP_TARGET);
  assign start     = do_target & (qlen != '0);
  assign advance   = (state == ST_RUN) & (~out_valid | ~out_stall);
  assign row_num   = LW'(idx) + LW'(1);
  assign last_row  = (row_num == qlen);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_score    <= MATCH_RESET;
      mismatch_score <= MISMATCH_RESET;
      gap_cost       <= GAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MATCH:    match_score    <= $signed(cfg_data);
        REG_MISMATCH: mismatch_score <= $signed(cfg_data);
        REG_GAP:      gap_cost       <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Query store. A load beyond a full store is dropped unless it restarts.
  assign q_wr_en   = do_load & (first | (qlen != LW'(MAX_QUERY)));
  assign q_wr_addr = first ? '0 : qlen[AW-1:0];
  assign rd_addr   = start ? '0 : idx + AW'(1);

  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      qmem[q_wr_addr] <= norm_base(base);
    end
  end

  always_ff @(posedge clk) begin
    if (col_ctl.rd_en) begin
      q_rd <= qmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qlen <= '0;
    end else if (q_wr_en) begin
      qlen <= (first ? '0 : qlen) + LW'(1);
    end
  end

  // Previous column: the cell at row i-1 is written back while row i+1 is read.
  assign col_ctl.clear = do_target & first;
  assign col_ctl.rd_en = start | (advance & ~last_row);
  assign col_ctl.wr_en = (advance & (idx != '0)) | (state == ST_FIN);
  assign col_wr_addr   = (state == ST_FIN) ? idx : idx - AW'(1);

  las_colmem #(
    .DEPTH (MAX_QUERY),
    .AW    (AW)
  ) u_colmem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (col_ctl),
    .rd_addr (rd_addr),
    .wr_addr (col_wr_addr),
    .wr_data (up_val),
    .rd_data (left_val)
  );

  las_cell u_cell (
    .qbase          (q_rd),
    .tbase          (tbase),
    .match_score    (match_score),
    .mismatch_score (mismatch_score),
    .gap_cost       (gap_cost),
    .diag           (diag_val),
    .up             (up_val),
    .left           (left_val),
    .best           (cell_best),
    .trace          (cell_trace)
  );

  // Column sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            idx   <= '0;
          end
        end
        ST_RUN: begin
          if (advance) begin
            if (last_row) begin
              state <= ST_FIN;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The left value of this row is the diagonal value of the next one.
  always_ff @(posedge clk) begin
    if (start) begin
      diag_val <= '0;
      up_val   <= '0;
      tbase    <= norm_base(base);
    end else if (advance) begin
      diag_val <= left_val;
      up_val   <= cell_best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row   <= ROW_W'(row_num);
      score <= cell_best;
      trace <= cell_trace;
      last  <= last_row;
    end
  end

`ifndef ASSERT_OFF
  a_col_no_clash: assert property (@(posedge clk) disable iff (rst)
    (col_ctl.rd_en && col_ctl.wr_en) |-> (rd_addr != col_wr_addr))
    else $error("column read and write hit the same entry");

  a_row_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (LW'(idx) < qlen))
    else $error("row counter beyond query length");

  a_fin_after_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> ($past(state) == ST_RUN && $past(last_row)))
    else $error("column closed without finishing its last row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !advance)
    else $error("result overwritten while stalled");
`endif

endmodule
